// ===== rtl/dspv_pkg.sv =====
`timescale 1ns / 1ps

package dspv_pkg;

    // default field accumulator width and queue depth
    localparam int FIELD_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // width of the result value ports
    localparam int OUT_WIDTH = 16;

    // width of a residue modulo 25
    localparam int MOD_BITS = 5;
    localparam int MOD_BASE = 25;

    // characters
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // field being read
    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;

    // months
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // month lengths
    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_LEAP  = 5'd29;
    localparam logic [4:0] LEN_FEB   = 5'd28;
    localparam logic [4:0] LEN_NONE  = 5'd0;

    // residue modulo 25 of a value up to 249, quotient by reciprocal 41/1024
    function automatic logic [MOD_BITS-1:0] mod25(input logic [7:0] t);
        logic [13:0] p;
        logic [3:0]  q;
        p = 14'(t) * 14'd41;
        q = p[13:10];
        return MOD_BITS'(t - 8'(q) * 8'd25);
    endfunction

endpackage

// ===== rtl/dspv_fifo.sv =====
`timescale 1ns / 1ps

module dspv_fifo #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/dspv_front.sv =====
`timescale 1ns / 1ps

module dspv_front #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_char_in,
    output logic                   o_rec_push,
    output logic [FIELD_WIDTH-1:0] o_rec_day,
    output logic [FIELD_WIDTH-1:0] o_rec_month,
    output logic [FIELD_WIDTH-1:0] o_rec_year,
    output logic [dspv_pkg::MOD_BITS-1:0] o_rec_ymod,
    output logic                   o_rec_check
);
    import dspv_pkg::*;

    localparam int FW = FIELD_WIDTH;
    localparam logic [FW-1:0] FIELD_MAX = {FW{1'b1}};
    localparam logic [MOD_BITS-1:0] MAX_MOD =
        MOD_BITS'(((64'(1) << FW) - 64'(1)) % MOD_BASE);

    logic [1:0]          r_idx, n_idx;
    logic [FW-1:0]       r_accum, n_accum;
    logic [MOD_BITS-1:0] r_mod, n_mod;
    logic                r_frozen, n_frozen;
    logic [FW-1:0]       r_day, n_day;
    logic [FW-1:0]       r_month, n_month;

    logic                is_digit, is_delim;
    logic [3:0]          digit;
    logic [FW+3:0]       grown;
    logic                sat;
    logic [7:0]          mod_sum;

    // character classes and next accumulator value
    assign is_digit = (i_char_in >= CHAR_ZERO) && (i_char_in <= CHAR_NINE);
    assign is_delim = (i_char_in == CHAR_DOT) || (i_char_in == CHAR_NUL);
    assign digit    = i_char_in[3:0];
    assign grown    = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) + (FW+4)'(digit);
    assign sat      = (grown[FW+3:FW] != 4'd0);
    assign mod_sum  = 8'(r_mod) * 8'd10 + 8'(digit);

    // parser state transitions and record emission
    always_comb begin
        n_idx       = r_idx;
        n_accum     = r_accum;
        n_mod       = r_mod;
        n_frozen    = r_frozen;
        n_day       = r_day;
        n_month     = r_month;
        o_rec_push  = 1'b0;
        o_rec_day   = r_accum;
        o_rec_month = '0;
        o_rec_year  = '0;
        o_rec_ymod  = r_mod;
        o_rec_check = 1'b0;
        if (r_idx == FIELD_MONTH) begin
            o_rec_day   = r_day;
            o_rec_month = r_accum;
        end else if (r_idx != FIELD_DAY) begin
            o_rec_day   = r_day;
            o_rec_month = r_month;
            o_rec_year  = r_accum;
            o_rec_check = 1'b1;
        end
        if (i_accept) begin
            if (is_digit) begin
                if (!r_frozen) begin
                    n_accum = sat ? FIELD_MAX : grown[FW-1:0];
                    n_mod   = sat ? MAX_MOD : mod25(mod_sum);
                end
            end else if (!is_delim) begin
                n_frozen = 1'b1;
            end else if (r_idx == FIELD_DAY && i_char_in == CHAR_DOT) begin
                n_day    = r_accum;
                n_idx    = FIELD_MONTH;
                n_accum  = '0;
                n_mod    = '0;
                n_frozen = 1'b0;
            end else if (r_idx == FIELD_MONTH && i_char_in == CHAR_DOT) begin
                n_month  = r_accum;
                n_idx    = FIELD_YEAR;
                n_accum  = '0;
                n_mod    = '0;
                n_frozen = 1'b0;
            end else begin
                o_rec_push = 1'b1;
                n_idx      = FIELD_DAY;
                n_accum    = '0;
                n_mod      = '0;
                n_frozen   = 1'b0;
                n_day      = '0;
                n_month    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= FIELD_DAY;
            r_accum  <= '0;
            r_mod    <= '0;
            r_frozen <= 1'b0;
            r_day    <= '0;
            r_month  <= '0;
        end else begin
            r_idx    <= n_idx;
            r_accum  <= n_accum;
            r_mod    <= n_mod;
            r_frozen <= n_frozen;
            r_day    <= n_day;
            r_month  <= n_month;
        end
    end

endmodule

// ===== rtl/dspv_back.sv =====
`timescale 1ns / 1ps

module dspv_back #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rec_empty,
    output logic                   o_rec_pop,
    input  logic [FIELD_WIDTH-1:0] i_rec_day,
    input  logic [FIELD_WIDTH-1:0] i_rec_month,
    input  logic [FIELD_WIDTH-1:0] i_rec_year,
    input  logic [dspv_pkg::MOD_BITS-1:0] i_rec_ymod,
    input  logic                   i_rec_check,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_day_out,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_month_out,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_year_out,
    output logic                   o_date_ok
);
    import dspv_pkg::*;

    localparam int FW = FIELD_WIDTH;

    logic           r_valid;
    logic [OUT_WIDTH-1:0] r_day, r_month, r_year;
    logic           r_ok;

    logic           div4, div16, div25, leap;
    logic           month_small;
    logic [4:0]     mlen;
    logic           ok;

    // output register frees up when empty or being taken
    assign o_rec_pop = !i_rec_empty && (!r_valid || i_pop);

    // gregorian leap rule, using divisibility by 100 = by 4 and by 25
    assign div4  = (i_rec_year[1:0] == 2'd0);
    assign div16 = (i_rec_year[3:0] == 4'd0);
    assign div25 = (i_rec_ymod == '0);
    assign leap  = div4 && (!div25 || div16);

    // month length
    assign month_small = ((i_rec_month >> 4) == '0);
    always_comb begin
        case (i_rec_month[3:0]) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC:
                mlen = LEN_LONG;
            MON_APR, MON_JUN, MON_SEP, MON_NOV:
                mlen = LEN_SHORT;
            MON_FEB:
                mlen = leap ? LEN_LEAP : LEN_FEB;
            default:
                mlen = LEN_NONE;
        endcase
        if (!month_small) begin
            mlen = LEN_NONE;
        end
    end

    assign ok = i_rec_check && (i_rec_day != '0) && (i_rec_day <= FW'(mlen))
                && (i_rec_year != '0);

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_day   <= OUT_WIDTH'(i_rec_day);
            r_month <= OUT_WIDTH'(i_rec_month);
            r_year  <= OUT_WIDTH'(i_rec_year);
            r_ok    <= ok;
        end
    end

    assign o_empty     = !r_valid;
    assign o_day_out   = r_day;
    assign o_month_out = r_month;
    assign o_year_out  = r_year;
    assign o_date_ok   = r_ok;

endmodule

// ===== rtl/date_string_parse_validate.sv =====
`timescale 1ns / 1ps

// date string parser and gregorian validator
// input queue side: one character per transaction on i_char_in, taken when
// i_push is high and o_full is low; a '.' or NUL closes a field and the
// third closed field (or a NUL earlier) makes one result
// result queue side: day, month, year and o_date_ok stand on the ports
// while o_empty is low and are taken when i_pop is high
// throughput: one character every cycle while o_full is low; the digit
// accumulator (times ten, add, saturate) and its running residue modulo 25
// are combinational and registered with each character taken; the parser
// writes the record into the queue at the edge that takes its closing
// character, and the validator's output register takes it from the queue when that register is empty or being popped
// the parser and the validator are split by a short record queue, so a
// stalled receiver first fills the output register, then the queue, and
// only then raises o_full; nothing is dropped
// reset: synchronous, active low; the parser restarts at the day field and
// both queues come up empty, with no clearing pass
module date_string_parse_validate #(
    parameter int FIELD_WIDTH = dspv_pkg::FIELD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = dspv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [7:0]                     i_char_in,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_day_out,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_month_out,
    output logic [dspv_pkg::OUT_WIDTH-1:0] o_year_out,
    output logic                           o_date_ok
);
    import dspv_pkg::*;

    localparam int FW = FIELD_WIDTH;
    localparam int RW = 3 * FW + MOD_BITS + 1;

    logic                accept;
    logic                f_push;
    logic [FW-1:0]       f_day, f_month, f_year;
    logic [MOD_BITS-1:0] f_ymod;
    logic                f_check;
    logic [RW-1:0]       q_wdata, q_rdata;
    logic                q_full, q_empty, q_pop;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    // parser front end
    dspv_front #(.FIELD_WIDTH(FW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_in   (i_char_in),
        .o_rec_push  (f_push),
        .o_rec_day   (f_day),
        .o_rec_month (f_month),
        .o_rec_year  (f_year),
        .o_rec_ymod  (f_ymod),
        .o_rec_check (f_check)
    );

    // record queue between parser and validator
    assign q_wdata = {f_day, f_month, f_year, f_ymod, f_check};

    dspv_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // validator back end
    dspv_back #(.FIELD_WIDTH(FW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (q_empty),
        .o_rec_pop   (q_pop),
        .i_rec_day   (q_rdata[RW-1 -: FW]),
        .i_rec_month (q_rdata[RW-FW-1 -: FW]),
        .i_rec_year  (q_rdata[RW-2*FW-1 -: FW]),
        .i_rec_ymod  (q_rdata[MOD_BITS:1]),
        .i_rec_check (q_rdata[0]),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_date_ok   (o_date_ok)
    );

endmodule
